>>> rtl/bir_pkg.sv
package bir_pkg;

  localparam int Side       = 128;
  localparam int CoordW     = 7;
  localparam int PixW       = 8;
  localparam int TrigW      = 16;
  localparam int TrigFrac   = 14;
  localparam int OutFrac    = 8;
  localparam int OutW       = 16;
  localparam int NumBanks   = 4;
  localparam int BankAddrW  = 2 * (CoordW - 1);
  localparam int BankDepth  = 1 << BankAddrW;
  localparam int DeltaW     = CoordW + 1;
  localparam int ProdW      = DeltaW + TrigW;
  localparam int PosW       = ProdW + 1;
  localparam int WeightW    = TrigFrac + 1;
  localparam int LerpW      = PixW + TrigFrac;
  localparam int AccW       = LerpW + TrigFrac;
  localparam int ShiftR     = 2 * TrigFrac - OutFrac;
  localparam int ApbAddrW   = 3;
  localparam int ApbDataW   = 32;

  localparam logic [WeightW-1:0] WeightOne = WeightW'(1 << TrigFrac);
  localparam logic [TrigW-1:0]   CosReset  = TrigW'(1 << TrigFrac);
  localparam logic [TrigW-1:0]   SinReset  = '0;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic {
    REG_COS = 1'b0,
    REG_SIN = 1'b1
  } reg_e;

  typedef struct packed {
    logic              opcode;
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
    logic [PixW-1:0]   pixel_in;
  } in_t;

  typedef struct packed {
    logic [OutW-1:0]   pixel_out;
    logic [CoordW-1:0] row_out;
    logic [CoordW-1:0] col_out;
  } out_t;

endpackage

>>> rtl/bilinear_image_rotation.sv
// Bilinear rotation of a 128x128 greyscale frame about its centre. One beat is
// taken per cycle with no gaps (busy is always low): a load writes one source
// pixel, a query returns the blended pixel at the inverse-rotated position with
// 8 fraction bits, on out_o for one cycle with out_strobe_o. The receiver cannot
// stall, so a result must be captured in that cycle. The rate is set by the
// four-bank frame store (banked by row and column parity), which yields all
// four neighbours in the same cycle; loads travel down the same pipe and write
// at the read stage, so beats act in order.
// Write cos_theta (address 0) and sin_theta (address 4) only while no query
// is in flight.
module bilinear_image_rotation (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  bir_pkg::in_t                      in_i,
  output logic                              out_strobe_o,
  output bir_pkg::out_t                     out_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bir_pkg::ApbAddrW-1:0]      paddr,
  input  logic [bir_pkg::ApbDataW-1:0]      pwdata,
  output logic [bir_pkg::ApbDataW-1:0]      prdata,
  output logic                              pready
);
  import bir_pkg::*;

  // config registers
  logic signed [TrigW-1:0] cos_q, cos_d, sin_q, sin_d;
  logic                    cfg_we;
  reg_e                    cfg_sel;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_sel = reg_e'(paddr[2]);

  always_comb begin
    cos_d = cos_q;
    sin_d = sin_q;
    if (cfg_we) begin
      case (cfg_sel)
        REG_COS: cos_d = pwdata[TrigW-1:0];
        REG_SIN: sin_d = pwdata[TrigW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_COS: prdata = {{(ApbDataW-TrigW){cos_q[TrigW-1]}}, cos_q};
      REG_SIN: prdata = {{(ApbDataW-TrigW){sin_q[TrigW-1]}}, sin_q};
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q <= CosReset;
      sin_q <= SinReset;
    end else begin
      cos_q <= cos_d;
      sin_q <= sin_d;
    end
  end

  // valid bits
  logic va_q, vb_q, vc_q, vd_q, ve_q, vf_q, vg_q, vo_q;
  in_t  c_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0; vb_q <= 1'b0; vc_q <= 1'b0; vd_q <= 1'b0;
      ve_q <= 1'b0; vf_q <= 1'b0; vg_q <= 1'b0; vo_q <= 1'b0;
    end else begin
      va_q <= start & ~busy;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q & (op_e'(c_q.opcode) == OP_QUERY);
      ve_q <= vd_q;
      vf_q <= ve_q;
      vg_q <= vf_q;
      vo_q <= vg_q;
    end
  end

  // stage a: input beat
  in_t a_q;
  always_ff @(posedge clk_i) begin
    if (start & ~busy) a_q <= in_i;
  end

  // stage b: rotation products
  logic signed [DeltaW-1:0] dx, dy;
  logic signed [ProdW-1:0]  dxc_q, dys_q, dxs_q, dyc_q;
  in_t                      b_q;
  assign dx = $signed({1'b0, a_q.col}) - DeltaW'(Side / 2);
  assign dy = $signed({1'b0, a_q.row}) - DeltaW'(Side / 2);

  always_ff @(posedge clk_i) begin
    b_q   <= a_q;
    dxc_q <= ProdW'(dx * cos_q);
    dys_q <= ProdW'(dy * sin_q);
    dxs_q <= ProdW'(dx * sin_q);
    dyc_q <= ProdW'(dy * cos_q);
  end

  // stage c: source position, floor and fraction
  localparam logic signed [PosW-1:0] Centre = PosW'((Side / 2) << TrigFrac);
  logic signed [PosW-1:0] xs, ys;
  logic [CoordW-1:0]      x0_q, y0_q;
  logic [TrigFrac-1:0]    fxc_q, fyc_q;
  assign xs = PosW'(dxc_q) - PosW'(dys_q) + Centre;
  assign ys = PosW'(dxs_q) + PosW'(dyc_q) + Centre;

  always_ff @(posedge clk_i) begin
    c_q   <= b_q;
    x0_q  <= xs[TrigFrac +: CoordW];
    y0_q  <= ys[TrigFrac +: CoordW];
    fxc_q <= xs[TrigFrac-1:0];
    fyc_q <= ys[TrigFrac-1:0];
  end

  // stage d: banked frame store, write for loads, four reads for queries
  logic [PixW-1:0]        rd_q [NumBanks];
  logic [CoordW-1:0]      y1, x1;
  logic                   x0b_q, y0b_q;
  logic [TrigFrac-1:0]    fxd_q, fyd_q;
  logic [CoordW-1:0]      rowd_q, cold_q;
  logic [BankAddrW-1:0]   wr_addr;
  assign y1      = y0_q + CoordW'(1);
  assign x1      = x0_q + CoordW'(1);
  assign wr_addr = {c_q.row[CoordW-1:1], c_q.col[CoordW-1:1]};

  for (genvar b = 0; b < NumBanks; b++) begin : g_bank
    localparam logic Pr = 1'((b >> 1) & 1);
    localparam logic Pc = 1'(b & 1);
    logic [PixW-1:0]      bank_mem [BankDepth];
    logic [CoordW-1:0]    rr, cc;
    logic [BankAddrW-1:0] rd_addr;
    logic                 we;
    assign rr      = (y0_q[0] == Pr) ? y0_q : y1;
    assign cc      = (x0_q[0] == Pc) ? x0_q : x1;
    assign rd_addr = {rr[CoordW-1:1], cc[CoordW-1:1]};
    assign we      = vc_q & (op_e'(c_q.opcode) == OP_LOAD)
                     & (c_q.row[0] == Pr) & (c_q.col[0] == Pc);

    always_ff @(posedge clk_i) begin
      if (we) bank_mem[wr_addr] <= c_q.pixel_in;
      rd_q[b] <= bank_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    x0b_q  <= x0_q[0];
    y0b_q  <= y0_q[0];
    fxd_q  <= fxc_q;
    fyd_q  <= fyc_q;
    rowd_q <= c_q.row;
    cold_q <= c_q.col;
  end

  // stage e: horizontal weight products
  logic [PixW-1:0]     p00, p01, p10, p11;
  logic [WeightW-1:0]  wx0, wx1;
  logic [LerpW-1:0]    m00_q, m01_q, m10_q, m11_q;
  logic [TrigFrac-1:0] fye_q;
  logic [CoordW-1:0]   rowe_q, cole_q;
  assign p00 = rd_q[{y0b_q, x0b_q}];
  assign p01 = rd_q[{y0b_q, ~x0b_q}];
  assign p10 = rd_q[{~y0b_q, x0b_q}];
  assign p11 = rd_q[{~y0b_q, ~x0b_q}];
  assign wx1 = {1'b0, fxd_q};
  assign wx0 = WeightOne - wx1;

  always_ff @(posedge clk_i) begin
    m00_q  <= LerpW'(p00 * wx0);
    m01_q  <= LerpW'(p01 * wx1);
    m10_q  <= LerpW'(p10 * wx0);
    m11_q  <= LerpW'(p11 * wx1);
    fye_q  <= fyd_q;
    rowe_q <= rowd_q;
    cole_q <= cold_q;
  end

  // stage f: top and bottom rows
  logic [LerpW-1:0]    top_q, bot_q;
  logic [TrigFrac-1:0] fyf_q;
  logic [CoordW-1:0]   rowf_q, colf_q;
  always_ff @(posedge clk_i) begin
    top_q  <= m00_q + m01_q;
    bot_q  <= m10_q + m11_q;
    fyf_q  <= fye_q;
    rowf_q <= rowe_q;
    colf_q <= cole_q;
  end

  // stage g: vertical weight products
  logic [WeightW-1:0] wy0, wy1;
  logic [AccW-1:0]    mt_q, mb_q;
  logic [CoordW-1:0]  rowg_q, colg_q;
  assign wy1 = {1'b0, fyf_q};
  assign wy0 = WeightOne - wy1;

  always_ff @(posedge clk_i) begin
    mt_q   <= AccW'(top_q * wy0);
    mb_q   <= AccW'(bot_q * wy1);
    rowg_q <= rowf_q;
    colg_q <= colf_q;
  end

  // output register
  logic [AccW-1:0] acc;
  out_t            out_q;
  assign acc = mt_q + mb_q;

  always_ff @(posedge clk_i) begin
    out_q.pixel_out <= acc[ShiftR +: OutW];
    out_q.row_out   <= rowg_q;
    out_q.col_out   <= colg_q;
  end

  assign out_strobe_o = vo_q;
  assign out_o        = out_q;

endmodule

>>> dv/rotation_sb_pkg.sv
package rotation_sb_pkg;

  import bir_pkg::*;

  class rotation_scoreboard;
    logic [PixW-1:0]         frame [Side*Side];
    bit                      covered [Side*Side];
    logic signed [TrigW-1:0] cos_q;
    logic signed [TrigW-1:0] sin_q;
    out_t                    expected_pixels [$];
    int unsigned             fails;

    function new();
      cos_q = CosReset;
      sin_q = SinReset;
      fails = 0;
    endfunction

    function void set_angle(reg_e idx, logic [TrigW-1:0] value);
      if (idx == REG_COS) begin
        cos_q = value;
      end else begin
        sin_q = value;
      end
    endfunction

    function int unsigned outstanding();
      return expected_pixels.size();
    endfunction

    function longint pixel_at(longint r, longint c);
      return longint'(frame[(r & (Side - 1)) * Side + (c & (Side - 1))]);
    endfunction

    // a neighbour the query would read that no load has been sent to yet,
    // marked as covered; -1 once all four are covered
    function int claim_tap(logic [CoordW-1:0] row, logic [CoordW-1:0] col);
      longint dx, dy, xs, ys, x0, y0;
      int     tap;
      dx = longint'(col) - Side / 2;
      dy = longint'(row) - Side / 2;
      xs = dx * longint'(cos_q) - dy * longint'(sin_q) + (longint'(Side / 2) <<< TrigFrac);
      ys = dx * longint'(sin_q) + dy * longint'(cos_q) + (longint'(Side / 2) <<< TrigFrac);
      x0 = xs >>> TrigFrac;
      y0 = ys >>> TrigFrac;
      for (int i = 0; i < 4; i++) begin
        tap = int'(((y0 + (i >> 1)) & (Side - 1)) * Side + ((x0 + (i & 1)) & (Side - 1)));
        if (!covered[tap]) begin
          covered[tap] = 1'b1;
          return tap;
        end
      end
      return -1;
    endfunction

    // loads update the store copy; queries get the inverse-rotated bilinear blend
    function void note_beat(in_t beat);
      longint dx, dy, xs, ys, x0, y0, fx, fy, wgt, top, bot, acc;
      out_t   want;
      if (beat.opcode == OP_LOAD) begin
        frame[{beat.row, beat.col}]   = beat.pixel_in;
        covered[{beat.row, beat.col}] = 1'b1;
        return;
      end
      wgt = longint'(1) <<< TrigFrac;
      dx  = longint'(beat.col) - Side / 2;
      dy  = longint'(beat.row) - Side / 2;
      xs  = dx * longint'(cos_q) - dy * longint'(sin_q) + (longint'(Side / 2) <<< TrigFrac);
      ys  = dx * longint'(sin_q) + dy * longint'(cos_q) + (longint'(Side / 2) <<< TrigFrac);
      x0  = xs >>> TrigFrac;
      y0  = ys >>> TrigFrac;
      fx  = xs & (wgt - 1);
      fy  = ys & (wgt - 1);
      top = pixel_at(y0, x0) * (wgt - fx) + pixel_at(y0, x0 + 1) * fx;
      bot = pixel_at(y0 + 1, x0) * (wgt - fx) + pixel_at(y0 + 1, x0 + 1) * fx;
      acc = top * (wgt - fy) + bot * fy;
      want.pixel_out = OutW'(acc >> ShiftR);
      want.row_out   = beat.row;
      want.col_out   = beat.col;
      expected_pixels.push_back(want);
    endfunction

    function void check_result(out_t got, longint unsigned stamp);
      out_t want;
      if (expected_pixels.size() == 0) begin
        $display("%0d ns: unexpected result beat, got pixel %h row %0d col %0d",
                 stamp, got.pixel_out, got.row_out, got.col_out);
        fails++;
        return;
      end
      want = expected_pixels.pop_front();
      if (got.pixel_out !== want.pixel_out) begin
        $display("%0d ns: pixel_out mismatch at (%0d,%0d): expected %h, actual %h",
                 stamp, want.row_out, want.col_out, want.pixel_out, got.pixel_out);
        fails++;
      end
      if (got.row_out !== want.row_out) begin
        $display("%0d ns: row_out mismatch: expected %0d, actual %0d",
                 stamp, want.row_out, got.row_out);
        fails++;
      end
      if (got.col_out !== want.col_out) begin
        $display("%0d ns: col_out mismatch: expected %0d, actual %0d",
                 stamp, want.col_out, got.col_out);
        fails++;
      end
    endfunction
  endclass

endpackage

>>> dv/tb_top.sv
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import bir_pkg::*;
  import rotation_sb_pkg::*;

  localparam int unsigned RandomItems = 1550;
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned CycleLimit  = 400000;
  localparam int          TrigLimits [3] = '{16384, -16384, 0};

  logic                clk_i   = 1'b0;
  logic                rst_ni  = 1'b0;
  logic                start   = 1'b0;
  logic                busy;
  in_t                 in_i    = '0;
  logic                out_strobe_o;
  out_t                out_o;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [ApbAddrW-1:0] paddr   = '0;
  logic [ApbDataW-1:0] pwdata  = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  rotation_scoreboard sb = new();
  int unsigned        send_idle_pct = 0;
  int unsigned        cycle_count   = 0;
  int unsigned        beats_sent    = 0;

  bilinear_image_rotation dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .in_i         (in_i),
    .out_strobe_o (out_strobe_o),
    .out_o        (out_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_strobe_o) begin
        sb.check_result(out_o, $time);
      end
      if (start && !busy) begin
        sb.note_beat(in_i);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_beat(input in_t beat);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    in_i  <= beat;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    beats_sent++;
  endtask

  task automatic send_item(input op_e op, input int r, input int c, input int pix);
    in_t beat;
    beat.opcode   = op;
    beat.row      = CoordW'(r);
    beat.col      = CoordW'(c);
    beat.pixel_in = PixW'(pix);
    send_beat(beat);
  endtask

  // load every neighbour the query reads that has not been loaded, then query
  task automatic send_query(input int r, input int c, input int pix);
    int tap;
    tap = sb.claim_tap(CoordW'(r), CoordW'(c));
    while (tap >= 0) begin
      send_item(OP_LOAD, tap / Side, tap % Side, $urandom_range(255));
      tap = sb.claim_tap(CoordW'(r), CoordW'(c));
    end
    send_item(OP_QUERY, r, c, pix);
  endtask

  // drop start, let every query retire and any trailing load settle
  task automatic quiesce();
    start <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_angle(input reg_e idx, input logic [TrigW-1:0] value);
    logic [ApbAddrW-1:0] addr;
    logic [ApbDataW-1:0] readback;
    addr = ApbAddrW'(idx) << 2;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {{(ApbDataW - TrigW){value[TrigW-1]}}, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.set_angle(idx, value);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback[TrigW-1:0] !== value) begin
      $display("%0d ns: register %s readback mismatch: expected %h, actual %h",
               $time, idx.name(), value, readback[TrigW-1:0]);
      sb.fails++;
    end
  endtask

  initial begin
    int unsigned         base;
    int unsigned         sent;
    int unsigned         n;
    int                  r;
    int                  c;
    logic [TrigW-1:0]    cos_v;
    logic [TrigW-1:0]    sin_v;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_angle(REG_COS, CosReset);
    write_angle(REG_SIN, SinReset);

    // corners, wrap-around neighbours and pixel extremes
    send_item(OP_LOAD, 0, 0, 255);
    send_item(OP_LOAD, 0, 1, 0);
    send_item(OP_LOAD, 1, 0, 0);
    send_item(OP_LOAD, 1, 1, 255);
    send_item(OP_LOAD, 127, 127, 255);
    send_item(OP_LOAD, 127, 0, 0);
    send_item(OP_LOAD, 0, 127, 255);
    send_query(0, 0, 255);
    send_query(127, 127, 0);
    send_query(0, 127, 0);
    send_query(127, 0, 0);
    send_query(64, 64, 0);
    send_query(63, 63, 0);
    quiesce();
    write_angle(REG_COS, TrigW'(-16384));
    send_query(0, 0, 0);
    send_query(127, 127, 0);
    send_query(64, 64, 0);
    quiesce();
    // register patterns outside the unit circle
    write_angle(REG_COS, 16'h7fff);
    write_angle(REG_SIN, 16'h8000);
    send_query(0, 0, 0);
    send_query(127, 127, 0);
    send_query(1, 126, 0);
    quiesce();
    write_angle(REG_COS, TrigW'(11585));
    write_angle(REG_SIN, TrigW'(11585));
    send_query(0, 0, 0);
    send_query(32, 96, 0);

    base = beats_sent;
    while (beats_sent - base < RandomItems) begin
      quiesce();
      case ($urandom_range(3))
        0: begin
          cos_v = TrigW'(TrigLimits[$urandom_range(2)]);
          sin_v = TrigW'(TrigLimits[$urandom_range(2)]);
        end
        1: begin
          cos_v = TrigW'($urandom);
          sin_v = TrigW'($urandom);
        end
        default: begin
          cos_v = TrigW'($urandom_range(32768) - 16384);
          sin_v = TrigW'($urandom_range(32768) - 16384);
        end
      endcase
      write_angle(REG_COS, cos_v);
      write_angle(REG_SIN, sin_v);
      n = $urandom_range(80, 20);
      for (int unsigned k = 0; k < n && beats_sent - base < RandomItems; k++) begin
        sent = beats_sent - base;
        send_idle_pct = (sent < RandomItems / 3) ? 35 :
                        (sent < 2 * RandomItems / 3) ? 45 : 0;
        r = int'($urandom_range(127));
        c = int'($urandom_range(127));
        if ($urandom_range(99) < 40) begin
          send_item(OP_LOAD, r, c, $urandom_range(255));
        end else begin
          send_query(r, c, $urandom_range(255));
        end
      end
    end

    quiesce();
    if (sb.fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/bir_pkg.sv
rtl/bilinear_image_rotation.sv
dv/rotation_sb_pkg.sv
dv/tb_top.sv
